[src/rsi_pkg.sv]
// ----------------------------------------------------------------------------
// rsi_pkg: shared types and constants of the ray / sphere intersection core
// Fixed-point formats, datapath widths, register indexes and the words that
// travel from the front end through the queue into the back end.
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int HIT_EPSILON = 7;
  localparam int NORM_FRAC   = 14;

  localparam int CRD_W  = 32;                 // Q16.16 coordinate
  localparam int RAD_W  = 31;                 // radius, unsigned
  localparam int TV_W   = CRD_W + 1;          // origin minus center
  localparam int A_W    = 2 * CRD_W;          // D.D, unsigned
  localparam int H_W    = 2 * CRD_W + 2;      // T.D, signed
  localparam int C_W    = 2 * CRD_W + 3;      // T.T - r*r, signed
  localparam int MAG_W  = 66;                 // magnitude of h and c
  localparam int HALF_W = MAG_W / 2;          // chunk of the wide multiply
  localparam int DISC_W = 2 * MAG_W;          // quarter discriminant, signed
  localparam int ROOT_W = DISC_W / 2;         // floor square root
  localparam int NUM_W  = ROOT_W + 2;         // -h +- s, signed
  localparam int T_W    = 31;                 // hit distance
  localparam int DIVN_W = NUM_W - 1 + FRAC_BITS;
  localparam int REM_W  = A_W + T_W;          // root divider remainder
  localparam int PRD_W  = 2 * CRD_W;          // t * D
  localparam int STEP_W = PRD_W - FRAC_BITS;  // t * D >> FRAC_BITS
  localparam int PS_W   = STEP_W + 1;         // sum before saturation
  localparam int VLIM   = 40;                 // |T + t*D| clamps to 2^VLIM
  localparam int VMAG_W = VLIM + 1;
  localparam int NRM_W  = 16;
  localparam int NQ_W   = NRM_W - 1;
  localparam int NDIV_W = VMAG_W + NORM_FRAC;

  localparam logic [T_W-1:0]   T_MAX   = {T_W{1'b1}};
  localparam logic [T_W-1:0]   T_EPS   = T_W'(HIT_EPSILON);
  localparam logic [NRM_W-1:0] NRM_MAX = {1'b0, {NQ_W{1'b1}}};
  localparam logic [NRM_W-1:0] NRM_MIN = {1'b1, {NQ_W{1'b0}}};

  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_CENTER_Z = 2'd2,
    REG_RADIUS   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic                       skip;
    logic [A_W-1:0]             a;
    logic [H_W-1:0]             h;
    logic [2:0][CRD_W-1:0]      org;
    logic [2:0][CRD_W-1:0]      dir;
    logic [2:0][TV_W-1:0]       tv;
  } ctx_t;

  typedef struct packed {
    logic                       miss;
    ctx_t                       ctx;
    logic [DISC_W-1:0]          disc;
  } q_word_t;

  typedef struct packed {
    logic                       hit;
    logic [T_W-1:0]             distance;
    logic [2:0][CRD_W-1:0]      pt;
    logic [2:0][NRM_W-1:0]      nrm;
  } res_t;

endpackage

[src/rsi_front.sv]
// ----------------------------------------------------------------------------
// rsi_front: ray setup and classification
// Forms T = O - C, a = D.D, h = T.D, c = T.T - r*r and the quarter
// discriminant h*h - a*c over seven stages; flags a miss.
// ----------------------------------------------------------------------------
module rsi_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                take,
  input  logic [2:0][rsi_pkg::CRD_W-1:0]      org,
  input  logic [2:0][rsi_pkg::CRD_W-1:0]      dir,
  input  logic                                skip,
  input  logic [2:0][rsi_pkg::CRD_W-1:0]      cen,
  input  logic [rsi_pkg::RAD_W-1:0]           radius,
  output logic                                word_valid,
  output rsi_pkg::q_word_t                    word
);
  import rsi_pkg::*;

  // stage 1: register the ray, subtract the center
  logic                       v1_r;
  logic [2:0][CRD_W-1:0]      org1_r, dir1_r;
  logic [2:0][TV_W-1:0]       tv1_r;
  logic                       skip1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= take;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      org1_r  <= org;
      dir1_r  <= dir;
      skip1_r <= skip;
      for (int i = 0; i < 3; i++) begin
        tv1_r[i] <= TV_W'($signed(org[i])) - TV_W'($signed(cen[i]));
      end
    end
  end

  // stage 2: per-axis products
  logic signed [A_W-1:0]     dd_c [3];
  logic signed [A_W:0]       td_c [3];
  logic signed [A_W+1:0]     tt_c [3];
  logic [2*RAD_W-1:0]        rr_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dd_c[i] = $signed(dir1_r[i]) * $signed(dir1_r[i]);
      td_c[i] = $signed(tv1_r[i]) * $signed(dir1_r[i]);
      tt_c[i] = $signed(tv1_r[i]) * $signed(tv1_r[i]);
    end
    rr_c = radius * radius;
  end

  logic                       v2_r;
  logic [A_W-1:0]             dd2_r [3];
  logic [A_W:0]               td2_r [3];
  logic [A_W+1:0]             tt2_r [3];
  logic [2*RAD_W-1:0]         rr2_r;
  logic [2:0][CRD_W-1:0]      org2_r, dir2_r;
  logic [2:0][TV_W-1:0]       tv2_r;
  logic                       skip2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dd2_r[i] <= dd_c[i];
      td2_r[i] <= td_c[i];
      tt2_r[i] <= tt_c[i];
    end
    rr2_r   <= rr_c;
    org2_r  <= org1_r;
    dir2_r  <= dir1_r;
    tv2_r   <= tv1_r;
    skip2_r <= skip1_r;
  end

  // stage 3: sums
  logic            v3_r;
  ctx_t            ctx3_r;
  logic [C_W-1:0]  c3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    ctx3_r.skip <= skip2_r;
    ctx3_r.org  <= org2_r;
    ctx3_r.dir  <= dir2_r;
    ctx3_r.tv   <= tv2_r;
    ctx3_r.a    <= dd2_r[0] + dd2_r[1] + dd2_r[2];
    ctx3_r.h    <= H_W'($signed(td2_r[0])) + H_W'($signed(td2_r[1]))
                 + H_W'($signed(td2_r[2]));
    c3_r        <= C_W'(tt2_r[0]) + C_W'(tt2_r[1]) + C_W'(tt2_r[2]) - C_W'(rr2_r);
  end

  // stage 4: magnitudes for the wide multiplies
  logic              v4_r;
  ctx_t              ctx4_r;
  logic [MAG_W-1:0]  hmag4_r, cmag4_r;
  logic              cneg4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    ctx4_r  <= ctx3_r;
    hmag4_r <= ctx3_r.h[H_W-1] ? MAG_W'(-ctx3_r.h) : MAG_W'(ctx3_r.h);
    cmag4_r <= c3_r[C_W-1] ? MAG_W'(-c3_r) : MAG_W'(c3_r);
    cneg4_r <= c3_r[C_W-1];
  end

  // stage 5: partial products on half-width chunks
  logic [MAG_W-1:0]     amag4;
  logic                 v5_r;
  ctx_t                 ctx5_r;
  logic                 cneg5_r;
  logic [2*HALF_W-1:0]  hh5_r, hl5_r, hll5_r;
  logic [2*HALF_W-1:0]  ahh5_r, ahl5_r, alh5_r, all5_r;

  assign amag4 = MAG_W'(ctx4_r.a);

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else        v5_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    ctx5_r  <= ctx4_r;
    cneg5_r <= cneg4_r;
    hh5_r   <= hmag4_r[MAG_W-1:HALF_W] * hmag4_r[MAG_W-1:HALF_W];
    hl5_r   <= hmag4_r[MAG_W-1:HALF_W] * hmag4_r[HALF_W-1:0];
    hll5_r  <= hmag4_r[HALF_W-1:0] * hmag4_r[HALF_W-1:0];
    ahh5_r  <= amag4[MAG_W-1:HALF_W] * cmag4_r[MAG_W-1:HALF_W];
    ahl5_r  <= amag4[MAG_W-1:HALF_W] * cmag4_r[HALF_W-1:0];
    alh5_r  <= amag4[HALF_W-1:0] * cmag4_r[MAG_W-1:HALF_W];
    all5_r  <= amag4[HALF_W-1:0] * cmag4_r[HALF_W-1:0];
  end

  // stage 6: recombine h*h and |a*c|
  logic               v6_r;
  ctx_t               ctx6_r;
  logic               cneg6_r;
  logic [DISC_W-1:0]  h2_6_r, ac6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else        v6_r <= v5_r;
  end

  always_ff @(posedge clk) begin
    ctx6_r  <= ctx5_r;
    cneg6_r <= cneg5_r;
    h2_6_r  <= (DISC_W'(hh5_r) << (2 * HALF_W)) + (DISC_W'(hl5_r) << (HALF_W + 1))
             + DISC_W'(hll5_r);
    ac6_r   <= (DISC_W'(ahh5_r) << (2 * HALF_W))
             + ((DISC_W'(ahl5_r) + DISC_W'(alh5_r)) << HALF_W) + DISC_W'(all5_r);
  end

  // stage 7: discriminant and classification
  logic [DISC_W-1:0] disc_c;
  logic              v7_r;
  q_word_t           word7_r;

  assign disc_c = cneg6_r ? (h2_6_r + ac6_r) : (h2_6_r - ac6_r);

  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else        v7_r <= v6_r;
  end

  always_ff @(posedge clk) begin
    word7_r.ctx  <= ctx6_r;
    word7_r.disc <= disc_c;
    word7_r.miss <= (ctx6_r.a == '0) | disc_c[DISC_W-1];
  end

  assign word_valid = v7_r;
  assign word       = word7_r;

endmodule

[src/rsi_queue.sv]
// ----------------------------------------------------------------------------
// rsi_queue: short queue between front and back end
// Holds classified rays; drops a push only when full.
// ----------------------------------------------------------------------------
module rsi_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rsi_pkg::q_word_t  push_word,
  input  logic              pop,
  output rsi_pkg::q_word_t  head,
  output logic              empty,
  output logic              full
);
  import rsi_pkg::*;

  q_word_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]    count_r;
  logic               do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == (QPTR_W+1)'(QDEPTH));
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      priority if (do_push && !do_pop) count_r <= count_r + 1'b1;
      else if (do_pop && !do_push)     count_r <= count_r - 1'b1;
      else                             count_r <= count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_word;
  end

endmodule

[src/rsi_back.sv]
// ----------------------------------------------------------------------------
// rsi_back: root solve, hit point and normal
// Pipelined square root, two pipelined root dividers, root selection,
// hit point and a three-lane pipelined normal divider.
// ----------------------------------------------------------------------------
module rsi_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       word_valid,
  input  rsi_pkg::q_word_t           word,
  input  logic [rsi_pkg::RAD_W-1:0]  radius,
  output logic                       res_valid,
  output rsi_pkg::res_t              res
);
  import rsi_pkg::*;

  typedef struct packed {
    logic                   miss;
    ctx_t                   ctx;
  } bctx_t;

  typedef struct packed {
    logic                   hit;
    logic                   nzero;
    logic [T_W-1:0]         t;
    logic [2:0][CRD_W-1:0]  pt;
    logic [2:0]             vneg;
  } nctx_t;

  // square root, one result bit per stage
  logic               sq_v_r    [ROOT_W+1];
  bctx_t              sq_ctx_r  [ROOT_W+1];
  logic [DISC_W-1:0]  sq_rem_r  [ROOT_W+1];
  logic [ROOT_W-1:0]  sq_root_r [ROOT_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) sq_v_r[0] <= 1'b0;
    else        sq_v_r[0] <= word_valid;
  end

  always_ff @(posedge clk) begin
    sq_ctx_r[0].miss <= word.miss;
    sq_ctx_r[0].ctx  <= word.ctx;
    sq_rem_r[0]      <= word.disc;
    sq_root_r[0]     <= '0;
  end

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sq
    localparam int B = ROOT_W - 1 - j;
    logic [DISC_W-1:0] trial;
    logic              take;

    assign trial = (DISC_W'(sq_root_r[j]) << (B + 1)) + (DISC_W'(1) << (2 * B));
    assign take  = (sq_rem_r[j] >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) sq_v_r[j+1] <= 1'b0;
      else        sq_v_r[j+1] <= sq_v_r[j];
    end

    always_ff @(posedge clk) begin
      sq_ctx_r[j+1]  <= sq_ctx_r[j];
      sq_rem_r[j+1]  <= take ? (sq_rem_r[j] - trial) : sq_rem_r[j];
      sq_root_r[j+1] <= sq_root_r[j] | (take ? (ROOT_W'(1) << B) : '0);
    end
  end

  // numerators -h - s and -h + s
  logic              nm_v_r;
  bctx_t             nm_ctx_r;
  logic [NUM_W-1:0]  nm_num_r [2];
  logic [NUM_W-1:0]  hs_c, ss_c;

  assign hs_c = NUM_W'($signed(sq_ctx_r[ROOT_W].ctx.h));
  assign ss_c = NUM_W'(sq_root_r[ROOT_W]);

  always_ff @(posedge clk) begin
    if (!rst_n) nm_v_r <= 1'b0;
    else        nm_v_r <= sq_v_r[ROOT_W];
  end

  always_ff @(posedge clk) begin
    nm_ctx_r    <= sq_ctx_r[ROOT_W];
    nm_num_r[0] <= -hs_c - ss_c;
    nm_num_r[1] <= -hs_c + ss_c;
  end

  // root dividers: (num << FRAC_BITS) / a, one quotient bit per stage
  logic              dv_v_r    [T_W+1];
  bctx_t             dv_ctx_r  [T_W+1];
  logic [REM_W-1:0]  dv_rem_r  [T_W+1][2];
  logic [T_W-1:0]    dv_q_r    [T_W+1][2];
  logic [1:0]        dv_ovf_r  [T_W+1];
  logic [1:0]        dv_zero_r [T_W+1];
  logic [REM_W-1:0]  dv_n_c    [2];
  logic [REM_W-1:0]  dv_lim_c;

  always_comb begin
    dv_lim_c = REM_W'(nm_ctx_r.ctx.a) << T_W;
    for (int r = 0; r < 2; r++) begin
      dv_n_c[r] = REM_W'(DIVN_W'(nm_num_r[r][NUM_W-2:0]) << FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_v_r[0] <= 1'b0;
    else        dv_v_r[0] <= nm_v_r;
  end

  always_ff @(posedge clk) begin
    dv_ctx_r[0] <= nm_ctx_r;
    for (int r = 0; r < 2; r++) begin
      dv_rem_r[0][r]  <= dv_n_c[r];
      dv_q_r[0][r]    <= '0;
      dv_ovf_r[0][r]  <= (dv_n_c[r] >= dv_lim_c);
      dv_zero_r[0][r] <= nm_num_r[r][NUM_W-1] | (nm_num_r[r] == '0);
    end
  end

  for (genvar k = 0; k < T_W; k++) begin : g_dv
    localparam int B = T_W - 1 - k;
    logic [REM_W-1:0] dvs;
    logic [1:0]       take;

    assign dvs = REM_W'(dv_ctx_r[k].ctx.a) << B;
    assign take[0] = (dv_rem_r[k][0] >= dvs);
    assign take[1] = (dv_rem_r[k][1] >= dvs);

    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[k+1] <= 1'b0;
      else        dv_v_r[k+1] <= dv_v_r[k];
    end

    always_ff @(posedge clk) begin
      dv_ctx_r[k+1]  <= dv_ctx_r[k];
      dv_ovf_r[k+1]  <= dv_ovf_r[k];
      dv_zero_r[k+1] <= dv_zero_r[k];
      for (int r = 0; r < 2; r++) begin
        dv_rem_r[k+1][r] <= take[r] ? (dv_rem_r[k][r] - dvs) : dv_rem_r[k][r];
        dv_q_r[k+1][r]   <= dv_q_r[k][r] | (take[r] ? (T_W'(1) << B) : '0);
      end
    end
  end

  // root selection: near root unless it is not past epsilon
  logic [T_W-1:0] rt_c [2];
  logic [T_W-1:0] tsel_c;

  always_comb begin
    for (int r = 0; r < 2; r++) begin
      priority if (dv_zero_r[T_W][r]) rt_c[r] = '0;
      else if (dv_ovf_r[T_W][r])      rt_c[r] = T_MAX;
      else                            rt_c[r] = dv_q_r[T_W][r];
    end
    tsel_c = (rt_c[0] > T_EPS) ? rt_c[0] : rt_c[1];
  end

  logic            sel_v_r;
  ctx_t            sel_ctx_r;
  logic [T_W-1:0]  sel_t_r;
  logic            sel_hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) sel_v_r <= 1'b0;
    else        sel_v_r <= dv_v_r[T_W];
  end

  always_ff @(posedge clk) begin
    sel_ctx_r <= dv_ctx_r[T_W].ctx;
    sel_t_r   <= tsel_c;
    sel_hit_r <= ~dv_ctx_r[T_W].miss & (tsel_c > T_EPS);
  end

  // t * D
  logic signed [PRD_W-1:0] prd_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prd_c[i] = $signed({1'b0, sel_t_r}) * $signed(sel_ctx_r.dir[i]);
    end
  end

  logic              mu_v_r;
  ctx_t              mu_ctx_r;
  logic [T_W-1:0]    mu_t_r;
  logic              mu_hit_r;
  logic [PRD_W-1:0]  mu_prd_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) mu_v_r <= 1'b0;
    else        mu_v_r <= sel_v_r;
  end

  always_ff @(posedge clk) begin
    mu_ctx_r <= sel_ctx_r;
    mu_t_r   <= sel_t_r;
    mu_hit_r <= sel_hit_r;
    for (int i = 0; i < 3; i++) mu_prd_r[i] <= prd_c[i];
  end

  // hit point and clamped offset T + t*D
  logic [PS_W-1:0]   ps_c   [3];
  logic [PS_W-1:0]   vs_c   [3];
  logic [PS_W-1:0]   vabs_c [3];
  logic [CRD_W-1:0]  psat_c [3];
  logic [VMAG_W-1:0] vmag_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // upper bits of the product are the floor of the shift
      ps_c[i] = PS_W'($signed(mu_ctx_r.org[i]))
              + PS_W'($signed(mu_prd_r[i][PRD_W-1:FRAC_BITS]));
      vs_c[i] = PS_W'($signed(mu_ctx_r.tv[i]))
              + PS_W'($signed(mu_prd_r[i][PRD_W-1:FRAC_BITS]));
      priority if (!ps_c[i][PS_W-1] && (|ps_c[i][PS_W-2:CRD_W-1]))
        psat_c[i] = {1'b0, {(CRD_W-1){1'b1}}};
      else if (ps_c[i][PS_W-1] && !(&ps_c[i][PS_W-2:CRD_W-1]))
        psat_c[i] = {1'b1, {(CRD_W-1){1'b0}}};
      else
        psat_c[i] = ps_c[i][CRD_W-1:0];
      vabs_c[i] = vs_c[i][PS_W-1] ? -vs_c[i] : vs_c[i];
      vmag_c[i] = (vabs_c[i] > (PS_W'(1) << VLIM)) ? (VMAG_W'(1) << VLIM)
                                                    : vabs_c[i][VMAG_W-1:0];
    end
  end

  logic               ad_v_r;
  nctx_t              ad_ctx_r;
  logic [VMAG_W-1:0]  ad_vmag_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) ad_v_r <= 1'b0;
    else        ad_v_r <= mu_v_r;
  end

  always_ff @(posedge clk) begin
    ad_ctx_r.hit   <= mu_hit_r;
    ad_ctx_r.nzero <= mu_ctx_r.skip;
    ad_ctx_r.t     <= mu_t_r;
    for (int i = 0; i < 3; i++) begin
      ad_ctx_r.pt[i]   <= psat_c[i];
      ad_ctx_r.vneg[i] <= vs_c[i][PS_W-1];
      ad_vmag_r[i]     <= vmag_c[i];
    end
  end

  // normal divider: (|V| << NORM_FRAC) / r, three lanes
  logic               nd_v_r   [NQ_W+1];
  nctx_t              nd_ctx_r [NQ_W+1];
  logic [NDIV_W-1:0]  nd_rem_r [NQ_W+1][3];
  logic [NQ_W-1:0]    nd_q_r   [NQ_W+1][3];
  logic [2:0]         nd_ovf_r [NQ_W+1];
  logic [NDIV_W-1:0]  nd_n_c   [3];
  logic [NDIV_W-1:0]  nd_lim_c;

  always_comb begin
    nd_lim_c = NDIV_W'(radius) << NQ_W;
    for (int i = 0; i < 3; i++) nd_n_c[i] = NDIV_W'(ad_vmag_r[i]) << NORM_FRAC;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) nd_v_r[0] <= 1'b0;
    else        nd_v_r[0] <= ad_v_r;
  end

  always_ff @(posedge clk) begin
    nd_ctx_r[0].hit   <= ad_ctx_r.hit;
    nd_ctx_r[0].nzero <= ad_ctx_r.nzero | (radius == '0);
    nd_ctx_r[0].t     <= ad_ctx_r.t;
    nd_ctx_r[0].pt    <= ad_ctx_r.pt;
    nd_ctx_r[0].vneg  <= ad_ctx_r.vneg;
    for (int i = 0; i < 3; i++) begin
      nd_rem_r[0][i]    <= nd_n_c[i];
      nd_q_r[0][i]      <= '0;
      nd_ovf_r[0][i]    <= (nd_n_c[i] >= nd_lim_c);
    end
  end

  for (genvar k = 0; k < NQ_W; k++) begin : g_nd
    localparam int B = NQ_W - 1 - k;
    logic [NDIV_W-1:0] dvs;
    logic [2:0]        take;

    assign dvs = NDIV_W'(radius) << B;
    for (genvar i = 0; i < 3; i++) begin : g_lane
      assign take[i] = (nd_rem_r[k][i] >= dvs);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) nd_v_r[k+1] <= 1'b0;
      else        nd_v_r[k+1] <= nd_v_r[k];
    end

    always_ff @(posedge clk) begin
      nd_ctx_r[k+1] <= nd_ctx_r[k];
      nd_ovf_r[k+1] <= nd_ovf_r[k];
      for (int i = 0; i < 3; i++) begin
        nd_rem_r[k+1][i] <= take[i] ? (nd_rem_r[k][i] - dvs) : nd_rem_r[k][i];
        nd_q_r[k+1][i]   <= nd_q_r[k][i] | (take[i] ? (NQ_W'(1) << B) : '0);
      end
    end
  end

  // result assembly; a miss clears every field
  logic [NRM_W-1:0] nrm_c [3];
  nctx_t            fin;

  assign fin = nd_ctx_r[NQ_W];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      priority if (fin.nzero)     nrm_c[i] = '0;
      else if (nd_ovf_r[NQ_W][i]) nrm_c[i] = fin.vneg[i] ? NRM_MIN : NRM_MAX;
      else if (fin.vneg[i])       nrm_c[i] = -{1'b0, nd_q_r[NQ_W][i]};
      else                        nrm_c[i] = {1'b0, nd_q_r[NQ_W][i]};
    end
  end

  logic  res_valid_r;
  res_t  res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) res_valid_r <= 1'b0;
    else        res_valid_r <= nd_v_r[NQ_W];
  end

  always_ff @(posedge clk) begin
    if (fin.hit) begin
      res_r.hit      <= 1'b1;
      res_r.distance <= fin.t;
      res_r.pt       <= fin.pt;
      for (int i = 0; i < 3; i++) res_r.nrm[i] <= nrm_c[i];
    end else begin
      res_r <= '0;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

[src/ray_sphere_intersect_core.sv]
// ----------------------------------------------------------------------------
// ray_sphere_intersect_core: ray / sphere intersection
// Intersects one ray per cycle with a configured sphere while busy is low;
// reports distance, hit point and Q2.14 normal.
// ----------------------------------------------------------------------------
// A ray is taken on every clock edge with start high and busy low; one word
// of results follows per ray, in order, and is shown for exactly one cycle
// with out_valid high. There is no way to hold results off, so sample every
// out_valid cycle. The block takes a new ray every cycle while busy is low:
// the front end (seven stages: center offset, products, sums, the split wide
// multiplies and the discriminant) feeds a four-word queue, and the back end
// drains it one word a cycle. Most of the pipeline lies in the back end: a
// 66-stage square root, a 31-stage root divider and a 15-stage normal
// divider. Coordinates are signed Q16.16; a miss returns all-zero fields.
// Write the sphere registers (cfg_we, cfg_index, cfg_data) only when no ray
// is in flight.
// ----------------------------------------------------------------------------
module ray_sphere_intersect_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // ray input
  input  logic                               start,
  output logic                               busy,
  input  logic [rsi_pkg::CRD_W-1:0]          in_origin_x,
  input  logic [rsi_pkg::CRD_W-1:0]          in_origin_y,
  input  logic [rsi_pkg::CRD_W-1:0]          in_origin_z,
  input  logic [rsi_pkg::CRD_W-1:0]          in_dir_x,
  input  logic [rsi_pkg::CRD_W-1:0]          in_dir_y,
  input  logic [rsi_pkg::CRD_W-1:0]          in_dir_z,
  input  logic                               in_skip_normal,
  // sphere registers
  input  logic                               cfg_we,
  input  logic [rsi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rsi_pkg::CRD_W-1:0]          cfg_data,
  // results
  output logic                               out_valid,
  output logic                               out_hit,
  output logic [rsi_pkg::T_W-1:0]            out_hit_distance,
  output logic [rsi_pkg::CRD_W-1:0]          out_hit_point_x,
  output logic [rsi_pkg::CRD_W-1:0]          out_hit_point_y,
  output logic [rsi_pkg::CRD_W-1:0]          out_hit_point_z,
  output logic [rsi_pkg::NRM_W-1:0]          out_normal_x,
  output logic [rsi_pkg::NRM_W-1:0]          out_normal_y,
  output logic [rsi_pkg::NRM_W-1:0]          out_normal_z
);
  import rsi_pkg::*;

  // sphere registers; radius resets to 1.0
  logic [CRD_W-1:0] center_x_r, center_y_r, center_z_r;
  logic [RAD_W-1:0] radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      center_z_r <= '0;
      radius_r   <= RAD_W'(1) << FRAC_BITS;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_CENTER_X: center_x_r <= cfg_data;
        REG_CENTER_Y: center_y_r <= cfg_data;
        REG_CENTER_Z: center_z_r <= cfg_data;
        REG_RADIUS:   radius_r   <= cfg_data[RAD_W-1:0];
        default:      radius_r   <= radius_r;
      endcase
    end
  end

  // accept a ray whenever the queue has room
  logic     take;
  logic     fe_valid;
  q_word_t  fe_word;
  q_word_t  q_head;
  logic     q_empty, q_full;
  logic     be_valid;
  res_t     be_res;

  assign busy = q_full;
  assign take = start & ~busy;

  rsi_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .org        ({in_origin_z, in_origin_y, in_origin_x}),
    .dir        ({in_dir_z, in_dir_y, in_dir_x}),
    .skip       (in_skip_normal),
    .cen        ({center_z_r, center_y_r, center_x_r}),
    .radius     (radius_r),
    .word_valid (fe_valid),
    .word       (fe_word)
  );

  // back end never stalls: pop whenever a word waits
  rsi_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fe_valid),
    .push_word (fe_word),
    .pop       (~q_empty),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  rsi_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .word_valid (~q_empty),
    .word       (q_head),
    .radius     (radius_r),
    .res_valid  (be_valid),
    .res        (be_res)
  );

  assign out_valid        = be_valid;
  assign out_hit          = be_res.hit;
  assign out_hit_distance = be_res.distance;
  assign out_hit_point_x  = be_res.pt[0];
  assign out_hit_point_y  = be_res.pt[1];
  assign out_hit_point_z  = be_res.pt[2];
  assign out_normal_x     = be_res.nrm[0];
  assign out_normal_y     = be_res.nrm[1];
  assign out_normal_z     = be_res.nrm[2];

endmodule
